>>> sv/sndx_pkg.sv
package sndx_pkg;

  // default number of code positions
  localparam int CODE_LENGTH_DEF = 4;
  // positions carried on the result word
  localparam int NUM_OUT = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_UP_A  = 8'd65;
  localparam logic [7:0] ASCII_UP_Z  = 8'd90;
  localparam logic [7:0] ASCII_LO_A  = 8'd97;
  localparam logic [7:0] ASCII_LO_Z  = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  // upper bits of an ASCII digit '0'..'7' in six bits
  localparam logic [2:0] DIGIT_HIGH  = 3'b110;

  // classified input word, passed from front to back
  typedef struct packed {
    logic       is_letter;
    logic [4:0] letter_idx;
    logic [2:0] digit;
    logic       last;
  } item_t;

  // letter A..Z to soundex digit
  function automatic logic [2:0] letter_digit(input logic [4:0] idx);
    logic [2:0] d;
    case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                        d = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: d = 3'd2;
      5'd3, 5'd19:                                     d = 3'd3;
      5'd11:                                           d = 3'd4;
      5'd12, 5'd13:                                    d = 3'd5;
      5'd17:                                           d = 3'd6;
      default:                                         d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

>>> sv/soundex_encoder_core.sv
// Soundex encoder: a string streams in one byte per word (tuser high when the byte belongs
// to the string, tlast on its final word) and one 4-character code comes out per string.
// A byte is taken every cycle while the queue has room; the front classifies it (case fold,
// letter check, digit table) into a two-entry queue, and the back applies one queued word
// per cycle to the code state unless a result is held back; the last byte passes a queue
// slot and then the result register. The result sits in an output register, so input keeps
// flowing while it waits; bytes stall only when both result register and queue are full.
module soundex_encoder_core #(
  parameter int CODE_LENGTH = sndx_pkg::CODE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic  [7:0] s_axis_tdata,   // char_byte
  input  logic        s_axis_tuser,   // char_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // code_letter, code_digit_1, code_digit_2, code_digit_3
);
  import sndx_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  // classify incoming bytes
  sndx_front u_front (
    .char_byte    (s_axis_tdata),
    .char_present (s_axis_tuser),
    .last         (s_axis_tlast),
    .item         (front_item)
  );

  // queue between front and back
  sndx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // code builder and result register
  sndx_back #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // a last word leaving the queue always produces a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_item.last) |=> m_axis_tvalid)
    else $error("last word consumed without a result");

  // after reset nothing is pending and input is open
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("state not clear after reset");

  // every result digit is an ASCII '0'..'6'
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[13:8] <= 6'd54) && (m_axis_tdata[13:8] >= 6'd48) &&
                       (m_axis_tdata[19:14] <= 6'd54) && (m_axis_tdata[19:14] >= 6'd48) &&
                       (m_axis_tdata[25:20] <= 6'd54) && (m_axis_tdata[25:20] >= 6'd48)))
    else $error("result digit out of range");

endmodule

>>> sv/sndx_front.sv
module sndx_front (
  input  logic              [7:0] char_byte,
  input  logic                    char_present,
  input  logic                    last,
  output sndx_pkg::item_t         item
);
  import sndx_pkg::*;

  logic [7:0] upper;
  logic [7:0] offset;

  // fold lower case to upper case
  always_comb begin
    if (char_byte >= ASCII_LO_A && char_byte <= ASCII_LO_Z) begin
      upper = char_byte - CASE_OFFSET;
    end else begin
      upper = char_byte;
    end
  end

  assign offset = upper - ASCII_UP_A;

  // classify and look up the digit
  always_comb begin
    item.is_letter  = char_present && (upper >= ASCII_UP_A) && (upper <= ASCII_UP_Z);
    item.letter_idx = offset[4:0];
    item.digit      = letter_digit(offset[4:0]);
    item.last       = last;
  end

endmodule

>>> sv/sndx_queue.sv
module sndx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sndx_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output sndx_pkg::item_t out_item
);
  import sndx_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // storage slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/sndx_back.sv
module sndx_back #(
  parameter int CODE_LENGTH = sndx_pkg::CODE_LENGTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sndx_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic     [31:0] out_data  // code_letter, code_digit_1, code_digit_2, code_digit_3
);
  import sndx_pkg::*;

  localparam int FW = $clog2(CODE_LENGTH + 1);

  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [2:0]    prev;
  logic [2:0]    prev_next;
  logic [7:0]    letter;
  logic [7:0]    letter_next;
  logic [2:0]    digit      [1:NUM_OUT-1];
  logic [2:0]    digit_next [1:NUM_OUT-1];
  logic          take;

  logic [7:0]    res_letter;
  logic [2:0]    res_digit  [1:NUM_OUT-1];

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // code state update for one word
  always_comb begin
    fill_next   = fill;
    prev_next   = prev;
    letter_next = letter;
    for (int k = 1; k < NUM_OUT; k++) begin
      digit_next[k] = digit[k];
    end
    if (in_item.is_letter && (fill < FW'(CODE_LENGTH))) begin
      if (fill == '0) begin
        letter_next = ASCII_UP_A + {3'b000, in_item.letter_idx};
        fill_next   = FW'(1);
      end else if ((in_item.digit != 3'd0) && (in_item.digit != prev)) begin
        for (int k = 1; k < NUM_OUT; k++) begin
          if (fill == FW'(k)) begin
            digit_next[k] = in_item.digit;
          end
        end
        fill_next = fill + FW'(1);
      end
      prev_next = in_item.digit;
    end
  end

  // code state, cleared after the last word of a string
  always_ff @(posedge clk) begin
    if (rst || (take && in_item.last)) begin
      fill   <= '0;
      prev   <= 3'd0;
      letter <= ASCII_ZERO;
      for (int k = 1; k < NUM_OUT; k++) begin
        digit[k] <= 3'd0;
      end
    end else if (take) begin
      fill   <= fill_next;
      prev   <= prev_next;
      letter <= letter_next;
      for (int k = 1; k < NUM_OUT; k++) begin
        digit[k] <= digit_next[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_item.last) begin
      res_letter <= letter_next;
      for (int k = 1; k < NUM_OUT; k++) begin
        res_digit[k] <= digit_next[k];
      end
    end
  end

  // digits leave as ASCII '0'..'6'
  assign out_data = {6'b000000,
                     DIGIT_HIGH, res_digit[3],
                     DIGIT_HIGH, res_digit[2],
                     DIGIT_HIGH, res_digit[1],
                     res_letter};

endmodule
